// ----- hw/rtl/tta_pkg.sv -----
// Shared types and microcode for the trie address allocator.
// Holds field widths, status codes, control word layout and the step table.
// Depends on nothing.
`timescale 1ns / 1ps

package tta_pkg;

  localparam int ADDR_BITS_DEFAULT = 8;
  localparam int ADDR_PORT_W       = 8;
  localparam int STATUS_W          = 2;
  localparam int COUNT_W           = 9;
  localparam int PC_W              = 4;

  // request operation codes
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OTHER     = 2'd1,
    STATUS_NONE_FREE = 2'd2,
    STATUS_NOT_TAKEN = 2'd3
  } status_t;

  // memory read address select
  typedef enum logic [2:0] {
    RD_ROOT    = 3'd0,
    RD_CHILD   = 3'd1,
    RD_SIBLING = 3'd2,
    RD_UPSIB   = 3'd3,
    RD_LEAF    = 3'd4
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE       = 2'd0,
    WR_SET_NODE   = 2'd1,
    WR_SET_PARENT = 2'd2,
    WR_CLR_NODE   = 2'd3
  } wr_sel_t;

  typedef enum logic [2:0] {
    N_HOLD    = 3'd0,
    N_ROOT    = 3'd1,
    N_LEAF    = 3'd2,
    N_DESCEND = 3'd3,
    N_PARENT  = 3'd4,
    N_INC     = 3'd5
  } node_op_t;

  typedef enum logic [1:0] {
    L_HOLD = 2'd0,
    L_INIT = 2'd1,
    L_DEC  = 2'd2
  } lvl_op_t;

  typedef enum logic [1:0] {
    C_HOLD = 2'd0,
    C_INC  = 2'd1,
    C_DEC  = 2'd2
  } cnt_op_t;

  typedef enum logic [1:0] {
    RES_NONE  = 2'd0,
    RES_ALLOC = 2'd1,
    RES_FULL  = 2'd2,
    RES_REL   = 2'd3
  } res_t;

  typedef enum logic [2:0] {
    CND_NEVER    = 3'd0,
    CND_ALWAYS   = 3'd1,
    CND_REL      = 3'd2,
    CND_FULL     = 3'd3,
    CND_MORE_LVL = 3'd4,
    CND_UP_STOP  = 3'd5,
    CND_NOT_ROOT = 3'd6,
    CND_CLR_MORE = 3'd7
  } cond_t;

  typedef struct packed {
    logic            accept;
    rd_sel_t         rd;
    wr_sel_t         wr;
    node_op_t        node_op;
    lvl_op_t         lvl_op;
    cnt_op_t         cnt_op;
    res_t            res;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // step addresses
  localparam logic [PC_W-1:0] ST_CLR      = 4'd0;
  localparam logic [PC_W-1:0] ST_FETCH    = 4'd1;
  localparam logic [PC_W-1:0] ST_ROOTCHK  = 4'd2;
  localparam logic [PC_W-1:0] ST_DRD      = 4'd3;
  localparam logic [PC_W-1:0] ST_DEVAL    = 4'd4;
  localparam logic [PC_W-1:0] ST_SETLEAF  = 4'd5;
  localparam logic [PC_W-1:0] ST_UPCHK    = 4'd6;
  localparam logic [PC_W-1:0] ST_UPSET    = 4'd7;
  localparam logic [PC_W-1:0] ST_ARES     = 4'd8;
  localparam logic [PC_W-1:0] ST_FRES     = 4'd9;
  localparam logic [PC_W-1:0] ST_RRD      = 4'd10;
  localparam logic [PC_W-1:0] ST_RLEAF    = 4'd11;
  localparam logic [PC_W-1:0] ST_RPATH    = 4'd12;
  localparam logic [PC_W-1:0] ST_RRES     = 4'd13;

  localparam ctrl_t CW_NOP = '{
    accept:  1'b0,
    rd:      RD_ROOT,
    wr:      WR_NONE,
    node_op: N_HOLD,
    lvl_op:  L_HOLD,
    cnt_op:  C_HOLD,
    res:     RES_NONE,
    cond:    CND_NEVER,
    target:  ST_CLR
  };

  // Control store. A true condition jumps to target, else the step counter advances.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t cw;
    cw = CW_NOP;
    unique case (pc)
      ST_CLR: begin
        cw.wr      = WR_CLR_NODE;
        cw.node_op = N_INC;
        cw.cond    = CND_CLR_MORE;
        cw.target  = ST_CLR;
      end
      ST_FETCH: begin
        cw.accept  = 1'b1;
        cw.rd      = RD_ROOT;
        cw.node_op = N_ROOT;
        cw.lvl_op  = L_INIT;
        cw.cond    = CND_REL;
        cw.target  = ST_RRD;
      end
      ST_ROOTCHK: begin
        cw.cond   = CND_FULL;
        cw.target = ST_FRES;
      end
      ST_DRD: begin
        cw.rd = RD_CHILD;
      end
      ST_DEVAL: begin
        cw.node_op = N_DESCEND;
        cw.lvl_op  = L_DEC;
        cw.cond    = CND_MORE_LVL;
        cw.target  = ST_DRD;
      end
      ST_SETLEAF: begin
        cw.wr     = WR_SET_NODE;
        cw.rd     = RD_SIBLING;
        cw.cnt_op = C_INC;
      end
      ST_UPCHK: begin
        cw.cond   = CND_UP_STOP;
        cw.target = ST_ARES;
      end
      ST_UPSET: begin
        cw.wr      = WR_SET_PARENT;
        cw.rd      = RD_UPSIB;
        cw.node_op = N_PARENT;
        cw.cond    = CND_ALWAYS;
        cw.target  = ST_UPCHK;
      end
      ST_ARES: begin
        cw.res    = RES_ALLOC;
        cw.cond   = CND_ALWAYS;
        cw.target = ST_FETCH;
      end
      ST_FRES: begin
        cw.res    = RES_FULL;
        cw.cond   = CND_ALWAYS;
        cw.target = ST_FETCH;
      end
      ST_RRD: begin
        cw.rd      = RD_LEAF;
        cw.node_op = N_LEAF;
      end
      ST_RLEAF: begin
        cw.wr      = WR_CLR_NODE;
        cw.node_op = N_PARENT;
        cw.cnt_op  = C_DEC;
      end
      ST_RPATH: begin
        cw.wr      = WR_CLR_NODE;
        cw.node_op = N_PARENT;
        cw.cond    = CND_NOT_ROOT;
        cw.target  = ST_RPATH;
      end
      ST_RRES: begin
        cw.res    = RES_REL;
        cw.cond   = CND_ALWAYS;
        cw.target = ST_FETCH;
      end
      default: begin
        cw.cond   = CND_ALWAYS;
        cw.target = ST_FETCH;
      end
    endcase
    return cw;
  endfunction

endpackage

// ----- hw/rtl/trie_address_allocator.sv -----
// Top level of the trie address allocator: microcoded sequencer, full-mark memory, result register.
// Depends on tta_pkg for widths, status codes and the control store.
`timescale 1ns / 1ps

// Channel  Signals                                   Direction  Transfer when
// req      req_valid, req_stall, op, addr            in         req_valid && !req_stall
// rsp      rsp_valid, rsp_stall, granted_addr,       out        rsp_valid && !rsp_stall
//          status, free_count
//
// After reset a clearing pass writes every mark, with req stalled. Allocate walks down
// from the root and marks the leaf and each level above it that becomes full; when no address
// is free it goes from the root check straight to the result. Release clears the leaf and each
// node up to the root. With the single-port read of the mark memory the descent takes two steps
// per tree level. req is taken only in the fetch step; a result waits in the output register
// while the next request is worked on, and only the result step holds while rsp is stalled.
module trie_address_allocator #(
  parameter int ADDR_BITS = tta_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic                             op,
  input  logic [tta_pkg::ADDR_PORT_W-1:0]  addr,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic [tta_pkg::ADDR_PORT_W-1:0]  granted_addr,
  output logic [tta_pkg::STATUS_W-1:0]     status,
  output logic [tta_pkg::COUNT_W-1:0]      free_count
);

  localparam int AW         = ADDR_BITS;
  localparam int NW         = ADDR_BITS + 1;
  localparam int NODE_SLOTS = 1 << NW;
  localparam int LVL_W      = (ADDR_BITS > 1) ? $clog2(ADDR_BITS) : 1;

  logic [tta_pkg::PC_W-1:0] pc;
  logic [tta_pkg::PC_W-1:0] pc_next;
  tta_pkg::ctrl_t           cw;

  logic [NW-1:0]    node;
  logic [NW-1:0]    node_next;
  logic [LVL_W-1:0] lvl;
  logic [AW-1:0]    want;
  logic [AW-1:0]    got;
  logic             keep;
  logic             was_taken;
  logic [NW-1:0]    taken;

  logic             marks [NODE_SLOTS];
  logic             rdata;
  logic [NW-1:0]    raddr;
  logic [NW-1:0]    waddr;
  logic             we;
  logic             wdata;

  logic             hold;
  logic             take;
  logic             dbit;
  logic [NW-1:0]    child;
  logic [NW-1:0]    leaf;

  assign cw        = tta_pkg::ucode(pc);
  assign req_stall = !cw.accept;

  assign hold = (cw.accept && !req_valid) ||
                (cw.res != tta_pkg::RES_NONE && rsp_valid && rsp_stall);

  assign dbit  = keep ? want[lvl] : 1'b0;
  assign child = {node[AW-1:0], dbit};
  assign leaf  = {1'b1, want};

  always_comb begin
    unique case (cw.rd)
      tta_pkg::RD_ROOT:    raddr = NW'(1);
      tta_pkg::RD_CHILD:   raddr = child;
      tta_pkg::RD_SIBLING: raddr = node ^ NW'(1);
      tta_pkg::RD_UPSIB:   raddr = (node >> 1) ^ NW'(1);
      tta_pkg::RD_LEAF:    raddr = leaf;
      default:             raddr = NW'(1);
    endcase
  end

  always_comb begin
    we    = 1'b0;
    wdata = 1'b0;
    waddr = node;
    unique case (cw.wr)
      tta_pkg::WR_NONE:       we = 1'b0;
      tta_pkg::WR_SET_NODE: begin
        we    = !hold;
        wdata = 1'b1;
      end
      tta_pkg::WR_SET_PARENT: begin
        we    = !hold;
        wdata = 1'b1;
        waddr = node >> 1;
      end
      tta_pkg::WR_CLR_NODE:   we = !hold;
      default:                we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      marks[waddr] <= wdata;
    end
    rdata <= marks[raddr];
  end

  always_comb begin
    unique case (cw.cond)
      tta_pkg::CND_NEVER:    take = 1'b0;
      tta_pkg::CND_ALWAYS:   take = 1'b1;
      tta_pkg::CND_REL:      take = (op == tta_pkg::OP_RELEASE);
      tta_pkg::CND_FULL:     take = rdata;
      tta_pkg::CND_MORE_LVL: take = (lvl != '0);
      tta_pkg::CND_UP_STOP:  take = (node == NW'(1)) || !rdata;
      tta_pkg::CND_NOT_ROOT: take = (node != NW'(1));
      tta_pkg::CND_CLR_MORE: take = (node != {NW{1'b1}});
      default:               take = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = cw.target;
    end else begin
      pc_next = pc + tta_pkg::PC_W'(1);
    end
  end

  always_comb begin
    unique case (cw.node_op)
      tta_pkg::N_HOLD:    node_next = node;
      tta_pkg::N_ROOT:    node_next = NW'(1);
      tta_pkg::N_LEAF:    node_next = leaf;
      tta_pkg::N_DESCEND: node_next = child ^ NW'(rdata);
      tta_pkg::N_PARENT:  node_next = node >> 1;
      tta_pkg::N_INC:     node_next = node + NW'(1);
      default:            node_next = node;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc    <= tta_pkg::ST_CLR;
      node  <= '0;
      taken <= '0;
    end else begin
      pc <= pc_next;
      if (!hold) begin
        node <= node_next;
        unique case (cw.cnt_op)
          tta_pkg::C_HOLD: taken <= taken;
          tta_pkg::C_INC:  taken <= taken + NW'(1);
          tta_pkg::C_DEC: begin
            if (rdata && taken != '0) begin
              taken <= taken - NW'(1);
            end
          end
          default:         taken <= taken;
        endcase
      end
    end
  end

  // walk registers: path bits, preference flag, level
  always_ff @(posedge clk) begin
    if (!hold) begin
      if (cw.accept) begin
        want <= AW'(addr);
      end
      unique case (cw.lvl_op)
        tta_pkg::L_HOLD: lvl <= lvl;
        tta_pkg::L_INIT: begin
          lvl  <= LVL_W'(ADDR_BITS - 1);
          keep <= 1'b1;
          got  <= '0;
        end
        tta_pkg::L_DEC:  lvl <= lvl - LVL_W'(1);
        default:         lvl <= lvl;
      endcase
      if (cw.node_op == tta_pkg::N_DESCEND) begin
        // a full child flips the bit and drops the preference for good
        got  <= (got << 1) | AW'(dbit ^ rdata);
        keep <= keep & !rdata;
      end
      if (cw.cnt_op == tta_pkg::C_DEC) begin
        was_taken <= rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!hold && cw.res != tta_pkg::RES_NONE) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold && cw.res != tta_pkg::RES_NONE) begin
      free_count <= tta_pkg::COUNT_W'({1'b1, {AW{1'b0}}} - taken);
      unique case (cw.res)
        tta_pkg::RES_ALLOC: begin
          granted_addr <= tta_pkg::ADDR_PORT_W'(got);
          status       <= (got == want) ? tta_pkg::STATUS_OK : tta_pkg::STATUS_OTHER;
        end
        tta_pkg::RES_FULL: begin
          granted_addr <= '0;
          status       <= tta_pkg::STATUS_NONE_FREE;
        end
        tta_pkg::RES_REL: begin
          granted_addr <= '0;
          status       <= was_taken ? tta_pkg::STATUS_OK : tta_pkg::STATUS_NOT_TAKEN;
        end
        default: begin
          granted_addr <= '0;
          status       <= tta_pkg::STATUS_OK;
        end
      endcase
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for trie_address_allocator: directed and random allocate/release traffic.
// Predicts each response with its own copy of the mark tree and taken counter.
// Depends on tta_pkg (widths, status codes) and the RTL top level.
`timescale 1ns / 1ps

module tb_top;

  localparam int TREE_DEPTH = tta_pkg::ADDR_BITS_DEFAULT;
  localparam int LEAVES     = 1 << TREE_DEPTH;
  localparam int NODES      = 1 << (TREE_DEPTH + 1);
  localparam int RAND_ITEMS = 1200;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_kind_t;

  typedef struct {
    logic [tta_pkg::ADDR_PORT_W-1:0] grant;
    tta_pkg::status_t                code;
    logic [tta_pkg::COUNT_W-1:0]     nfree;
  } alloc_result_t;

  class alloc_scoreboard;
    bit            marks[NODES];
    int unsigned   taken;
    alloc_result_t owed[$];
    int unsigned   errors;
    int unsigned   checked;
    int unsigned   seen_code[4];

    function void clear_tree();
      foreach (marks[i]) marks[i] = 1'b0;
      taken = 0;
    endfunction

    // Random taken address, or -1 when nothing is allocated.
    function int pick_taken();
      int start;
      int a;
      start = $urandom_range(0, LEAVES - 1);
      for (int i = 0; i < LEAVES; i++) begin
        a = (start + i) % LEAVES;
        if (marks[LEAVES + a]) return a;
      end
      return -1;
    endfunction

    function void note_request(logic o, logic [tta_pkg::ADDR_PORT_W-1:0] a);
      alloc_result_t r;
      int node;
      int child;
      int par;
      int got;
      bit keep;
      bit b;
      r.grant = '0;
      if (o == tta_pkg::OP_ALLOC) begin
        if (marks[1]) begin
          r.code = tta_pkg::STATUS_NONE_FREE;
        end else begin
          node = 1;
          got  = 0;
          keep = 1'b1;
          for (int lvl = TREE_DEPTH - 1; lvl >= 0; lvl--) begin
            b = keep ? a[lvl] : 1'b0;
            child = 2 * node + b;
            // subtree full: take the sibling and go lowest-first from here
            if (marks[child]) begin
              b = ~b;
              child = child ^ 1;
              keep = 1'b0;
            end
            got  = 2 * got + b;
            node = child;
          end
          marks[node] = 1'b1;
          while (node > 1) begin
            par = node / 2;
            if (!(marks[2 * par] && marks[2 * par + 1])) break;
            marks[par] = 1'b1;
            node = par;
          end
          taken++;
          r.grant = got[tta_pkg::ADDR_PORT_W-1:0];
          r.code  = (got == int'(a)) ? tta_pkg::STATUS_OK : tta_pkg::STATUS_OTHER;
        end
      end else begin
        node = LEAVES + int'(a);
        b = marks[node];
        while (node >= 1) begin
          marks[node] = 1'b0;
          node = node / 2;
        end
        if (b) begin
          if (taken > 0) taken--;
          r.code = tta_pkg::STATUS_OK;
        end else begin
          r.code = tta_pkg::STATUS_NOT_TAKEN;
        end
      end
      r.nfree = tta_pkg::COUNT_W'(LEAVES - taken);
      owed.push_back(r);
    endfunction

    function void check_result(logic [tta_pkg::ADDR_PORT_W-1:0] g,
                               logic [tta_pkg::STATUS_W-1:0] s,
                               logic [tta_pkg::COUNT_W-1:0] f);
      alloc_result_t e;
      checked++;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] response with nothing pending: addr %0d status %0d free %0d",
                   $realtime, g, s, f);
        return;
      end
      e = owed.pop_front();
      seen_code[e.code]++;
      if (g !== e.grant || s !== e.code || f !== e.nfree) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] response %0d: exp addr %0d status %0d free %0d, got %0d %0d %0d",
                   $realtime, checked, e.grant, e.code, e.nfree, g, s, f);
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            req_valid;
  logic                            req_stall;
  logic                            op;
  logic [tta_pkg::ADDR_PORT_W-1:0] addr;
  logic                            rsp_valid;
  logic                            rsp_stall;
  logic [tta_pkg::ADDR_PORT_W-1:0] granted_addr;
  logic [tta_pkg::STATUS_W-1:0]    status;
  logic [tta_pkg::COUNT_W-1:0]     free_count;

  alloc_scoreboard sb = new();
  int unsigned     sent;
  int unsigned     rx_hold_req;
  bit              tx_gaps_on;
  bit              rx_gaps_on;

  trie_address_allocator u_dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .op           (op),
    .addr         (addr),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .granted_addr (granted_addr),
    .status       (status),
    .free_count   (free_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Hold valid and payload until the transfer, then optionally drop valid for a gap.
  task automatic send_req(input logic o, input logic [tta_pkg::ADDR_PORT_W-1:0] a);
    bit done;
    int gap;
    req_valid <= 1'b1;
    op        <= o;
    addr      <= a;
    done = 1'b0;
    while (!done) begin
      @(posedge clk);
      if (req_stall === 1'b0) begin
        done = 1'b1;
        sb.note_request(o, a);
        sent++;
      end
      @(negedge clk);
    end
    gap = (tx_gaps_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      op        <= $urandom_range(0, 1);
      addr      <= $urandom_range(0, LEAVES - 1);
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_responses();
    req_valid <= 1'b0;
    @(negedge clk);
    while (sb.owed.size() != 0) @(negedge clk);
  endtask

  function automatic logic [tta_pkg::ADDR_PORT_W-1:0] pref_addr();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? '1 : '0;
    return $urandom_range(0, LEAVES - 1);
  endfunction

  task automatic run_phase(input phase_kind_t kind, input int len);
    int r;
    int t;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      t = sb.pick_taken();
      case (kind)
        PH_FILL: begin
          if (r < 90) send_req(tta_pkg::OP_ALLOC, pref_addr());
          else send_req(tta_pkg::OP_RELEASE, pref_addr());
        end
        PH_DRAIN: begin
          if (r < 85 && t >= 0) send_req(tta_pkg::OP_RELEASE, t[tta_pkg::ADDR_PORT_W-1:0]);
          else if (r < 95) send_req(tta_pkg::OP_RELEASE, pref_addr());
          else send_req(tta_pkg::OP_ALLOC, pref_addr());
        end
        default: begin
          if (r < 50) send_req(tta_pkg::OP_ALLOC, pref_addr());
          else if (r < 90 && t >= 0)
            send_req(tta_pkg::OP_RELEASE, t[tta_pkg::ADDR_PORT_W-1:0]);
          else send_req(tta_pkg::OP_RELEASE, pref_addr());
        end
      endcase
    end
  endtask

  // Response side: draw stalls, honor long hold requests, check every transfer.
  initial begin
    int stall_left;
    rsp_stall   = 1'b0;
    stall_left  = 0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        sb.check_result(granted_addr, status, free_count);
      @(negedge clk);
      if (stall_left == 0) begin
        if (rx_hold_req > 0) begin
          stall_left  = rx_hold_req;
          rx_hold_req = 0;
        end else if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
          stall_left = gap_len();
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin
    int rand_start;
    phase_kind_t kind;
    rst         = 1'b1;
    req_valid   = 1'b0;
    op          = tta_pkg::OP_ALLOC;
    addr        = '0;
    sent        = 0;
    rx_hold_req = 0;
    tx_gaps_on  = 1'b0;
    rx_gaps_on  = 1'b0;
    sb.clear_tree();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, fallback to sibling, double release
    send_req(tta_pkg::OP_RELEASE, 8'h00);
    send_req(tta_pkg::OP_ALLOC,   8'h00);
    send_req(tta_pkg::OP_ALLOC,   8'h00);
    send_req(tta_pkg::OP_ALLOC,   8'hFF);
    send_req(tta_pkg::OP_ALLOC,   8'hFF);
    send_req(tta_pkg::OP_ALLOC,   8'h80);
    send_req(tta_pkg::OP_ALLOC,   8'h7F);
    send_req(tta_pkg::OP_ALLOC,   8'h7F);
    send_req(tta_pkg::OP_RELEASE, 8'hFF);
    send_req(tta_pkg::OP_RELEASE, 8'hFF);
    send_req(tta_pkg::OP_ALLOC,   8'hAA);
    send_req(tta_pkg::OP_ALLOC,   8'h55);
    send_req(tta_pkg::OP_RELEASE, 8'h55);
    send_req(tta_pkg::OP_RELEASE, 8'h00);
    send_req(tta_pkg::OP_ALLOC,   8'h01);
    send_req(tta_pkg::OP_ALLOC,   8'h01);
    send_req(tta_pkg::OP_RELEASE, 8'h01);
    send_req(tta_pkg::OP_RELEASE, 8'h02);
    send_req(tta_pkg::OP_RELEASE, 8'h7F);
    send_req(tta_pkg::OP_RELEASE, 8'h80);
    drain_responses();

    // fill past full, then empty out, then random phases
    rand_start = sent;
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b0;
    run_phase(PH_FILL, 300);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b1;
    run_phase(PH_DRAIN, 280);
    drain_responses();
    rx_hold_req = 300;
    tx_gaps_on  = 1'b0;
    run_phase(PH_MIX, 60);
    while (sent - rand_start < RAND_ITEMS) begin
      kind = phase_kind_t'($urandom_range(0, 2));
      tx_gaps_on = $urandom_range(0, 1);
      rx_gaps_on = $urandom_range(0, 1);
      run_phase(kind, $urandom_range(20, 150));
      if ($urandom_range(0, 2) == 0) drain_responses();
    end
    req_valid <= 1'b0;

    while (sb.owed.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    sb.errors += sb.owed.size();
    $display("Sent %0d requests, checked %0d responses (%0d mismatches).",
             sent, sb.checked, sb.errors);
    $display("Status mix: ok %0d, other %0d, none free %0d, not allocated %0d.",
             sb.seen_code[tta_pkg::STATUS_OK], sb.seen_code[tta_pkg::STATUS_OTHER],
             sb.seen_code[tta_pkg::STATUS_NONE_FREE], sb.seen_code[tta_pkg::STATUS_NOT_TAKEN]);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("Timeout: %0d requests sent, %0d responses pending", sent, sb.owed.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
